### design/kher_pkg.sv
package kher_pkg;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_TICK = 2'd1,
    OP_MAP  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  localparam logic [0:0] REG_LONG_PRESS = 1'd0;
  localparam logic [0:0] REG_GAP        = 1'd1;

  localparam logic [7:0] LONG_PRESS_RESET = 8'd20;
  localparam logic [7:0] GAP_RESET        = 8'd6;
  localparam logic [7:0] GAP_MARK         = 8'h3f;
  localparam logic [7:0] HOLD_MAX         = 8'd255;

  typedef struct packed {
    op_t        op;
    logic [7:0] port_byte;
    logic [6:0] map_slot;
    logic [6:0] map_value;
    logic       player_sel;
    logic [3:0] ring_slot;
  } in_item_t;

  typedef struct packed {
    logic [6:0] last_key;
    logic [7:0] left_last_symbol;
    logic [7:0] right_last_symbol;
    logic [3:0] left_write_pos;
    logic [3:0] right_write_pos;
    logic [7:0] read_symbol;
  } out_item_t;

  function automatic logic [7:0] symbol_of(input logic [3:0] idx);
    logic [7:0] s;
    case (idx)
      4'd0:    s = 8'h75;
      4'd1:    s = 8'h6c;
      4'd2:    s = 8'h72;
      4'd3:    s = 8'h64;
      4'd4:    s = 8'h31;
      4'd5:    s = 8'h32;
      4'd6:    s = 8'h33;
      4'd7:    s = 8'h34;
      4'd8:    s = 8'h35;
      4'd9:    s = 8'h36;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    logic [7:0] u;
    if (c >= 8'h61 && c <= 8'h7a) begin
      u = c - 8'd32;
    end else begin
      u = c;
    end
    return u;
  endfunction

endpackage

### design/key_hold_event_ring_top.sv
// Keyboard event block with a hold-time counter per key and two symbol rings.
// Requests arrive on the in channel (in_valid, in_stall, in_data) and each
// request yields exactly one result on the out channel (out_valid, out_stall,
// out_data). A request is taken when valid is high and stall is low.
// The block works on one request at a time and stalls the input meanwhile.
// On a release, a scan byte reads and compares ring entries back from the
// write pointer, up to RING_DEPTH per side, on both sides when both are searched.
// A timer tick walks every hold counter but the last through the single read
// and write port of the counter memory, one entry per cycle.
// The result waits in an output register; while the receiver stalls, it is
// held unchanged and the block accepts the next request, finishing it only
// once the waiting result has been taken.
// Synchronous reset restores the register defaults and starts a clearing pass
// that zeroes one counter, map entry and entry of each ring per cycle, with
// the input stalled.
// Configuration writes take effect at once; the user makes them only while idle, as the block does not enforce it.
module key_hold_event_ring_top #(
  parameter int KEY_CODES  = 128,
  parameter int RING_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kher_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kher_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int KW = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CLR_N = (KEY_CODES > RING_DEPTH) ? KEY_CODES : RING_DEPTH;
  localparam int CW = $clog2(CLR_N);
  localparam logic [8:0] KEY_LIM = 9'(KEY_CODES);
  localparam logic [7:0] RING_LIM = 8'(RING_DEPTH);
  localparam logic [RW-1:0] RING_LAST = RW'(RING_DEPTH - 1);
  localparam logic [RW:0] RING_STEPS = (RW+1)'(RING_DEPTH);
  localparam logic [KW:0] TICK_END = (KW+1)'(KEY_CODES - 1);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);
  localparam logic [CW:0] CLR_KEYS = (CW+1)'(KEY_CODES);
  localparam logic [CW:0] CLR_RING = (CW+1)'(RING_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK_RD,
    S_MARK_CMP,
    S_TICK,
    S_TICK_IDLE,
    S_DONE
  } state_t;

  state_t state;

  logic [7:0] hold_mem [KEY_CODES];
  logic [6:0] map_mem [KEY_CODES];
  logic [7:0] lring [RING_DEPTH];
  logic [7:0] rring [RING_DEPTH];

  logic [7:0] long_press;
  logic [7:0] gap;
  logic [RW-1:0] lptr;
  logic [RW-1:0] rptr;
  logic [7:0] lidle;
  logic [7:0] ridle;
  logic [6:0] newest;
  logic [7:0] lsym;
  logic [7:0] rsym;

  kher_pkg::in_item_t req;
  logic [7:0] hold_q;
  logic [6:0] map_q;
  logic [7:0] ring_q;
  logic [7:0] rd_sym;
  logic [7:0] mark_c;
  logic [7:0] mark_cu;
  logic       mark_r;
  logic       side;
  logic [RW-1:0] ridx;
  logic [RW:0]   cnt;
  logic [KW:0]   tidx;
  logic [KW-1:0] taddr;
  logic          tpend;
  logic [CW-1:0] cidx;

  logic [8:0]    in_code;
  logic [KW-1:0] in_ci;
  logic [8:0]    in_slot;
  logic [KW-1:0] in_si;
  logic [7:0]    in_rslot;
  logic [RW-1:0] in_ri;
  logic [8:0]    req_code;
  logic [KW-1:0] req_ci;
  logic [7:0]    scan_c;
  logic [RW-1:0] ridx_prev;
  logic [RW-1:0] lptr_inc;
  logic [RW-1:0] rptr_inc;
  logic [7:0]    lidle_inc;
  logic [7:0]    ridle_inc;
  logic [7:0]    lpos_wide;
  logic [7:0]    rpos_wide;
  logic [CW:0]   cidx_wide;

  assign in_code   = {2'b00, in_data.port_byte[6:0]};
  assign in_ci     = in_code[KW-1:0];
  assign in_slot   = {2'b00, in_data.map_slot};
  assign in_si     = in_slot[KW-1:0];
  assign in_rslot  = {4'h0, in_data.ring_slot};
  assign in_ri     = in_rslot[RW-1:0];
  assign req_code  = {2'b00, req.port_byte[6:0]};
  assign req_ci    = req_code[KW-1:0];
  assign scan_c    = kher_pkg::symbol_of(map_q[3:0]);
  assign ridx_prev = (ridx == '0) ? RING_LAST : ridx - 1'b1;
  assign lptr_inc  = (lptr == RING_LAST) ? '0 : lptr + 1'b1;
  assign rptr_inc  = (rptr == RING_LAST) ? '0 : rptr + 1'b1;
  assign lidle_inc = lidle + 8'd1;
  assign ridle_inc = ridle + 8'd1;
  assign lpos_wide = 8'(lptr);
  assign rpos_wide = 8'(rptr);
  assign cidx_wide = {1'b0, cidx};

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cidx       <= '0;
      out_valid  <= 1'b0;
      long_press <= kher_pkg::LONG_PRESS_RESET;
      gap        <= kher_pkg::GAP_RESET;
      lptr       <= '0;
      rptr       <= '0;
      lidle      <= '0;
      ridle      <= '0;
      newest     <= '0;
      lsym       <= '0;
      rsym       <= '0;
      tpend      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          kher_pkg::REG_LONG_PRESS: long_press <= cfg_data;
          kher_pkg::REG_GAP:        gap <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          if (cidx_wide < CLR_KEYS) begin
            hold_mem[cidx[KW-1:0]] <= 8'd0;
            map_mem[cidx[KW-1:0]]  <= 7'd0;
          end
          if (cidx_wide < CLR_RING) begin
            lring[cidx[RW-1:0]] <= 8'd0;
            rring[cidx[RW-1:0]] <= 8'd0;
          end
          if (cidx == CLR_LAST) begin
            state <= S_IDLE;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req    <= in_data;
            rd_sym <= '0;
            case (in_data.op)
              kher_pkg::OP_SCAN: begin
                hold_q <= hold_mem[in_ci];
                map_q  <= map_mem[in_ci];
                state  <= (in_code < KEY_LIM) ? S_SCAN : S_DONE;
              end
              kher_pkg::OP_TICK: begin
                tidx  <= '0;
                tpend <= 1'b0;
                state <= S_TICK;
              end
              kher_pkg::OP_MAP: begin
                if (in_slot < KEY_LIM) begin
                  map_mem[in_si] <= in_data.map_value;
                end
                state <= S_DONE;
              end
              kher_pkg::OP_READ: begin
                if (in_rslot < RING_LIM) begin
                  if (in_data.player_sel) begin
                    rd_sym <= rring[in_ri];
                  end else begin
                    rd_sym <= lring[in_ri];
                  end
                end
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (!req.port_byte[7]) begin
            if (hold_q == 8'd0) begin
              hold_mem[req_ci] <= 8'd1;
              newest <= req.port_byte[6:0];
              if (map_q[6]) begin
                lidle       <= '0;
                lring[lptr] <= scan_c;
                lptr        <= lptr_inc;
                lsym        <= scan_c;
              end
              if (map_q[5]) begin
                ridle       <= '0;
                rring[rptr] <= scan_c;
                rptr        <= rptr_inc;
                rsym        <= scan_c;
              end
            end
            state <= S_DONE;
          end else begin
            mark_c  <= scan_c;
            mark_cu <= (hold_q > long_press) ? kher_pkg::upper_of(scan_c) : scan_c;
            hold_mem[req_ci] <= 8'd0;
            if (map_q[6]) begin
              lidle <= 8'd1;
            end
            if (map_q[5]) begin
              ridle <= 8'd1;
            end
            mark_r <= map_q[5];
            cnt    <= '0;
            if (map_q[6]) begin
              side  <= 1'b0;
              ridx  <= lptr;
              state <= S_MARK_RD;
            end else if (map_q[5]) begin
              side  <= 1'b1;
              ridx  <= rptr;
              state <= S_MARK_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MARK_RD: begin
          ridx <= ridx_prev;
          if (side) begin
            ring_q <= rring[ridx_prev];
          end else begin
            ring_q <= lring[ridx_prev];
          end
          cnt   <= cnt + 1'b1;
          state <= S_MARK_CMP;
        end
        S_MARK_CMP: begin
          if (ring_q != mark_c && cnt != RING_STEPS) begin
            state <= S_MARK_RD;
          end else begin
            if (ring_q == mark_c) begin
              if (side) begin
                rring[ridx] <= mark_cu;
              end else begin
                lring[ridx] <= mark_cu;
              end
            end
            if (!side && mark_r) begin
              side  <= 1'b1;
              ridx  <= rptr;
              cnt   <= '0;
              state <= S_MARK_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_TICK: begin
          if (tidx != TICK_END) begin
            hold_q <= hold_mem[tidx[KW-1:0]];
            taddr  <= tidx[KW-1:0];
            tpend  <= 1'b1;
            tidx   <= tidx + 1'b1;
          end else begin
            tpend <= 1'b0;
            if (!tpend) begin
              state <= S_TICK_IDLE;
            end
          end
          if (tpend && hold_q != 8'd0 && hold_q != kher_pkg::HOLD_MAX) begin
            hold_mem[taddr] <= hold_q + 8'd1;
          end
        end
        S_TICK_IDLE: begin
          if (lidle != 8'd0) begin
            if (lidle_inc > gap) begin
              lring[lptr] <= kher_pkg::GAP_MARK;
              lptr        <= lptr_inc;
              lidle       <= '0;
            end else begin
              lidle <= lidle_inc;
            end
          end
          if (ridle != 8'd0) begin
            if (ridle_inc > gap) begin
              rring[rptr] <= kher_pkg::GAP_MARK;
              rptr        <= rptr_inc;
              ridle       <= '0;
            end else begin
              ridle <= ridle_inc;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.last_key          <= newest;
            out_data.left_last_symbol  <= lsym;
            out_data.right_last_symbol <= rsym;
            out_data.left_write_pos    <= lpos_wide[3:0];
            out_data.right_write_pos   <= rpos_wide[3:0];
            out_data.read_symbol       <= rd_sym;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/kher_checker.sv
module kher_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input kher_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("A result is offered straight after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("The block took a second request while still working.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("A stalled result changed or vanished.");

endmodule

bind key_hold_event_ring_top kher_checker u_kher_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
